### rtl/selg_pkg.sv
package selg_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int PHASE_BITS_DEF = 24;

  // shared multiplier operand width
  localparam int MW = 32;
  localparam int MUL_DIGIT = 4;

  localparam int DUR_W = 22;
  localparam int DT_W = 16;
  localparam int RATE_W = 11;
  localparam int DEPTH_W = 16;
  localparam int DECAY_W = 16;
  localparam int ELAPSED_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [DUR_W-1:0] MIN_DURATION = DUR_W'(66);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_TRIG = 2'd1,
    OP_SOFT = 2'd2,
    OP_NOP  = 2'd3
  } selg_op_t;

  localparam logic [2:0] MODE_FREE     = 3'd0;
  localparam logic [2:0] MODE_ASC      = 3'd1;
  localparam logic [2:0] MODE_DESC     = 3'd2;
  localparam logic [2:0] MODE_OSC      = 3'd3;
  localparam logic [2:0] MODE_ASC_OSC  = 3'd4;
  localparam logic [2:0] MODE_DESC_OSC = 3'd5;

  localparam logic [1:0] CURVE_LIN    = 2'd0;
  localparam logic [1:0] CURVE_SQUARE = 2'd1;
  localparam logic [1:0] CURVE_SQRT   = 2'd2;
  localparam logic [1:0] CURVE_SMOOTH = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd6;

  // quarter-wave sine polynomial, Q30, Horner order
  localparam logic [31:0] SINE_K0 = 32'd172272;
  localparam logic [31:0] SINE_K [4] = '{32'd5026991, 32'd85569306,
                                         32'd693598668, 32'd1686629713};

  typedef struct packed {
    logic          start;
    logic [MW-1:0] a;
    logic [MW-1:0] b;
  } selg_mul_req_t;

endpackage

### rtl/selg_if.sv
interface selg_in_if import selg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [DT_W-1:0]   delta_time;
  modport source (output valid, output operation, output delta_time, input ready);
  modport sink (input valid, input operation, input delta_time, output ready);
endinterface

interface selg_out_if #(parameter int VB = 16);
  logic          valid;
  logic          ready;
  logic [VB-1:0] level;
  logic [VB-1:0] progress;
  modport source (output valid, output level, output progress, input ready);
  modport sink (input valid, input level, input progress, output ready);
endinterface

interface selg_cfg_if import selg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/shaped_envelope_lfo_generator.sv
// channel   dir   fields                          transaction
// in_ch     in    operation[1:0], delta_time[15:0] valid & ready
// out_ch    out   level[V-1:0], progress[V-1:0]   valid & ready
// cfg_ch    in    index[2:0], data[21:0]          valid & ready (ready always high)
//
// One item at a time. Trigger, soft restart and the unused code go straight to the output.
// A tick issues k multiplies on its path (2..13), each on the 4-bit-per-cycle shared
// multiplier, and may also use the divider or the root.
// Reset is synchronous; no clearing pass. A waiting result does not stop the
// next item being taken; it is only held back once the next result is ready.
module shaped_envelope_lfo_generator import selg_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  selg_in_if.sink  in_ch,
  selg_out_if.source out_ch,
  selg_cfg_if.sink cfg_ch
);

  localparam int V  = VALUE_BITS;
  localparam int P  = PHASE_BITS;
  localparam int RW = V + 3;
  localparam int BW = V + 2;
  localparam int SNAP_I = ((1 << V) + 999) / 1000;
  localparam int LS_L = (P >= 24) ? P - 24 : 0;
  localparam int LS_R = (P >= 24) ? 0 : 24 - P;

  localparam logic [V:0]     ONE  = {1'b1, {V{1'b0}}};
  localparam logic [V:0]     HALF = ONE >> 1;
  localparam logic [V+1:0]   SNAP = (V+2)'(SNAP_I);
  localparam logic signed [RW:0] BMAX = (RW+1)'((1 << (V + 1)) - 1);
  localparam logic signed [RW:0] BMIN = -(RW+1)'(1 << (V + 1));

  typedef enum logic [4:0] {
    S_IDLE, S_INC, S_DIV, S_PSET, S_SQ, S_SMO, S_SQRT, S_MODE, S_SZ, S_SH,
    S_SX, S_M3, S_EFF, S_CEN, S_ES, S_BR, S_DEC, S_OUT
  } state_t;

  state_t state_r;

  logic [2:0]         mode_r;
  logic [1:0]         curve_r;
  logic [DUR_W-1:0]   dur_r;
  logic [RATE_W-1:0]  rate_r;
  logic [DEPTH_W-1:0] depth_r;
  logic               loop_r;
  logic [DECAY_W-1:0] decay_r;

  logic [ELAPSED_W-1:0] elapsed_r;
  logic [P-1:0]         lfo_r;
  logic [V-1:0]         level_r;
  logic [V:0]           prog_r;
  logic signed [BW-1:0] bridge_r;
  logic [2:0]           pmode_r;
  logic [1:0]           pcurve_r;
  logic                 pvalid_r;

  logic [V-1:0]         pq_r;
  logic                 pge_r, wrap_r;
  logic [V:0]           c_r, sm_r, eff_r, cen_r;
  logic [30:0]          x_r, z_r;
  logic [1:0]           hk_r;
  logic                 sneg_r, bneg_r;
  logic signed [RW-1:0] raw_r;

  logic                 out_valid_r;
  logic [V-1:0]         out_level_r, out_prog_r;

  selg_mul_req_t        mreq_r;
  logic                 mul_done;
  logic [2*MW-1:0]      mul_p;
  logic                 div_start_r, div_done, sq_start_r, sq_done;
  logic [V-1:0]         div_q, sq_root;

  selg_mul u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq_r), .done(mul_done), .prod(mul_p)
  );

  selg_div #(.VALUE_BITS(V)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(elapsed_r[DUR_W-1:0]),
    .den(dur_r), .done(div_done), .quot(div_q)
  );

  selg_sqrt #(.VALUE_BITS(V)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start_r), .u(prog_r[V-1:0]),
    .done(sq_done), .root(sq_root)
  );

  function automatic selg_mul_req_t mk_mul(logic [MW-1:0] a, logic [MW-1:0] b);
    selg_mul_req_t r;
    r.start = 1'b1;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  // derived values
  logic [ELAPSED_W:0]   el_sum;
  logic [ELAPSED_W-1:0] el_sat;
  logic [63:0]          inc_w;
  logic [P-1:0]         inc_sh;
  logic                 asc, changed;
  logic [1:0]           lfo_q;
  logic [29:0]          f30;
  logic [30:0]          xs;
  logic [V+1:0]         pv, sx;
  logic [V:0]           cp;
  logic signed [RW:0]   diff, bsel;
  logic [V+1:0]         babs;
  logic signed [BW-1:0] bnew;
  logic signed [RW-1:0] lev;
  logic [31:0]          hr;

  always_comb begin
    el_sum = {1'b0, elapsed_r} + (ELAPSED_W+1)'(in_ch.delta_time);
    el_sat = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
    inc_w  = 64'(mul_p[RATE_W+DT_W-1:0]);
    inc_sh = (P >= 24) ? P'(inc_w << LS_L) : P'(inc_w >> LS_R);
    asc = (mode_r == MODE_ASC) || (mode_r == MODE_DESC) ||
          (mode_r == MODE_ASC_OSC) || (mode_r == MODE_DESC_OSC);
    changed = (mode_r != pmode_r) || (curve_r != pcurve_r);
    lfo_q = lfo_r[P-1 -: 2];
    f30 = 30'(lfo_r[P-3:0]) << (32 - P);
    xs = lfo_q[0] ? (31'(1) << 30) - {1'b0, f30} : {1'b0, f30};
    pv = mul_p[2*V+1:V];
    sx = mul_p[61:60-V];
    hr = SINE_K[hk_r] - mul_p[61:30];
    cp = (mode_r == MODE_DESC_OSC) ? ONE - c_r : c_r;
    diff = (RW+1)'($signed({3'b000, level_r})) - (RW+1)'(raw_r);
    if (wrap_r || (changed && pvalid_r)) begin
      bsel = (diff > BMAX) ? BMAX : (diff < BMIN) ? BMIN : diff;
    end else begin
      bsel = (RW+1)'(bridge_r);
    end
    babs = bsel[RW] ? (V+2)'(-bsel) : (V+2)'(bsel);
    bnew = (pv < SNAP) ? '0 : (bneg_r ? -$signed(BW'(pv)) : $signed(BW'(pv)));
    lev = raw_r + RW'(bnew);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_FREE;
      curve_r     <= CURVE_SMOOTH;
      dur_r       <= DUR_W'(524288);
      rate_r      <= RATE_W'(128);
      depth_r     <= DEPTH_W'(16384);
      loop_r      <= 1'b0;
      decay_r     <= DECAY_W'(58982);
      elapsed_r   <= '0;
      lfo_r       <= '0;
      level_r     <= HALF[V-1:0];
      prog_r      <= '0;
      bridge_r    <= '0;
      pmode_r     <= MODE_FREE;
      pcurve_r    <= CURVE_LIN;
      pvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mreq_r      <= '0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      wrap_r      <= 1'b0;
    end else begin
      mreq_r.start <= 1'b0;
      div_start_r  <= 1'b0;
      sq_start_r   <= 1'b0;
      if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_MODE:  mode_r  <= cfg_ch.data[2:0];
          REG_CURVE: curve_r <= cfg_ch.data[1:0];
          REG_DUR:   dur_r   <= cfg_ch.data[DUR_W-1:0];
          REG_RATE:  rate_r  <= cfg_ch.data[RATE_W-1:0];
          REG_DEPTH: depth_r <= cfg_ch.data[DEPTH_W-1:0];
          REG_LOOP:  loop_r  <= cfg_ch.data[0];
          REG_DECAY: decay_r <= cfg_ch.data[DECAY_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            wrap_r <= 1'b0;
            state_r <= S_OUT;
            case (selg_op_t'(in_ch.operation))
              OP_TICK: begin
                elapsed_r <= el_sat;
                mreq_r  <= mk_mul(MW'(rate_r), MW'(in_ch.delta_time));
                state_r <= S_INC;
              end
              OP_TRIG: begin
                elapsed_r <= '0;
                prog_r    <= '0;
                bridge_r  <= '0;
              end
              OP_SOFT: begin
                elapsed_r <= '0;
                prog_r    <= '0;
              end
              default: ;
            endcase
          end
        end
        S_INC: begin
          if (mul_done) begin
            lfo_r <= lfo_r + inc_sh;
            pq_r  <= '0;
            pge_r <= 1'b0;
            if (dur_r < MIN_DURATION) begin
              state_r <= S_PSET;
            end else if (elapsed_r >= ELAPSED_W'(dur_r)) begin
              pge_r   <= 1'b1;
              state_r <= S_PSET;
            end else begin
              div_start_r <= 1'b1;
              state_r     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            pq_r    <= div_q;
            state_r <= S_PSET;
          end
        end
        S_PSET: begin
          logic [V:0] p;
          p = pge_r ? ONE : {1'b0, pq_r};
          if (pge_r && asc && loop_r) begin
            elapsed_r <= '0;
            p = '0;
            wrap_r <= 1'b1;
          end
          prog_r <= p;
          case (curve_r)
            CURVE_LIN: begin
              c_r <= p;
              state_r <= S_MODE;
            end
            CURVE_SQRT: begin
              if (p == ONE) begin
                c_r <= ONE;
                state_r <= S_MODE;
              end else begin
                sq_start_r <= 1'b1;
                state_r <= S_SQRT;
              end
            end
            default: begin
              mreq_r  <= mk_mul(MW'(p), MW'(p));
              state_r <= S_SQ;
            end
          endcase
        end
        S_SQRT: begin
          if (sq_done) begin
            c_r <= {1'b0, sq_root};
            state_r <= S_MODE;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            if (curve_r == CURVE_SQUARE) begin
              c_r <= pv[V:0];
              state_r <= S_MODE;
            end else begin
              mreq_r <= mk_mul(MW'(pv), MW'(3 * (V+2)'(ONE) - 2 * (V+2)'(prog_r)));
              state_r <= S_SMO;
            end
          end
        end
        S_SMO: begin
          if (mul_done) begin
            c_r <= pv[V:0];
            state_r <= S_MODE;
          end
        end
        S_MODE: begin
          c_r <= cp;
          x_r <= xs;
          case (mode_r)
            MODE_ASC: begin
              raw_r <= RW'(c_r);
              state_r <= S_BR;
            end
            MODE_DESC: begin
              raw_r <= RW'(ONE - c_r);
              state_r <= S_BR;
            end
            MODE_OSC, MODE_ASC_OSC, MODE_DESC_OSC: begin
              mreq_r  <= mk_mul(MW'(xs), MW'(xs));
              state_r <= S_SZ;
            end
            default: begin
              raw_r <= RW'(HALF);
              state_r <= S_BR;
            end
          endcase
        end
        S_SZ: begin
          if (mul_done) begin
            z_r  <= mul_p[60:30];
            hk_r <= '0;
            mreq_r  <= mk_mul(MW'(mul_p[60:30]), SINE_K0);
            state_r <= S_SH;
          end
        end
        S_SH: begin
          if (mul_done) begin
            if (hk_r == 2'd3) begin
              mreq_r  <= mk_mul(MW'(x_r), hr);
              state_r <= S_SX;
            end else begin
              hk_r   <= hk_r + 2'd1;
              mreq_r <= mk_mul(MW'(z_r), hr);
            end
          end
        end
        S_SX: begin
          if (mul_done) begin
            logic [V:0] s;
            s = (sx > (V+2)'(ONE)) ? ONE : sx[V:0];
            sm_r   <= s;
            sneg_r <= lfo_q[1];
            if (mode_r == MODE_OSC) begin
              mreq_r  <= mk_mul(MW'(depth_r), MW'(s));
              state_r <= S_M3;
            end else begin
              mreq_r  <= mk_mul(MW'(depth_r), MW'(c_r));
              state_r <= S_EFF;
            end
          end
        end
        S_M3: begin
          if (mul_done) begin
            raw_r <= sneg_r ? RW'(HALF) - RW'(pv) : RW'(HALF) + RW'(pv);
            state_r <= S_BR;
          end
        end
        S_EFF: begin
          if (mul_done) begin
            eff_r   <= pv[V:0];
            mreq_r  <= mk_mul(MW'(c_r), MW'(ONE - pv[V:0]));
            state_r <= S_CEN;
          end
        end
        S_CEN: begin
          if (mul_done) begin
            cen_r   <= pv[V:0];
            mreq_r  <= mk_mul(MW'(eff_r), MW'(sm_r));
            state_r <= S_ES;
          end
        end
        S_ES: begin
          if (mul_done) begin
            raw_r <= sneg_r ? RW'(cen_r) - RW'(pv) : RW'(cen_r) + RW'(pv);
            state_r <= S_BR;
          end
        end
        S_BR: begin
          pmode_r  <= mode_r;
          pcurve_r <= curve_r;
          pvalid_r <= 1'b1;
          bneg_r   <= bsel[RW];
          mreq_r   <= mk_mul(MW'(babs), MW'(decay_r));
          state_r  <= S_DEC;
        end
        S_DEC: begin
          if (mul_done) begin
            bridge_r <= bnew;
            if (lev < 0) begin
              level_r <= '0;
            end else if (lev > RW'(ONE - 1)) begin
              level_r <= {V{1'b1}};
            end else begin
              level_r <= lev[V-1:0];
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_level_r <= level_r;
            out_prog_r  <= (prog_r == ONE) ? {V{1'b1}} : prog_r[V-1:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.level    = out_level_r;
  assign out_ch.progress = out_prog_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_no_mul_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mul_done)
    else $error("multiplier finished with no item in flight");

  a_prog_bound: assert property (@(posedge clk) disable iff (!rst_n)
    prog_r <= ONE)
    else $error("stored progress above one");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable(out_level_r) && $stable(out_prog_r)))
    else $error("pending result overwritten");

endmodule

### rtl/selg_mul.sv
module selg_mul import selg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  selg_mul_req_t     req,
  output logic              done,
  output logic [2*MW-1:0]   prod
);

  localparam int NDIG = MW / MUL_DIGIT;
  localparam int CW = $clog2(NDIG);

  logic [MW-1:0]   a_r, b_r;
  logic [2*MW-1:0] acc_r, acc_nxt;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;

  // one digit of b per cycle, most significant first
  assign acc_nxt = (acc_r << MUL_DIGIT)
                 + (2*MW)'(a_r * b_r[MW-1 -: MUL_DIGIT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= b_r << MUL_DIGIT;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NDIG - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/selg_div.sv
module selg_div import selg_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DUR_W-1:0]      num,
  input  logic [DUR_W-1:0]      den,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quot
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [DUR_W-1:0]      rem_r, den_r;
  logic [VALUE_BITS-1:0] q_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, done_r;
  logic [DUR_W:0]        rem2;
  logic                  ge;

  // num < den on entry, so the remainder always fits the divisor width
  assign rem2 = {rem_r, 1'b0};
  assign ge = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        den_r  <= den;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DUR_W'(rem2 - {1'b0, den_r}) : DUR_W'(rem2);
        q_r   <= {q_r[VALUE_BITS-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(VALUE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### rtl/selg_sqrt.sv
module selg_sqrt import selg_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] u,
  output logic                  done,
  output logic [VALUE_BITS-1:0] root
);

  localparam int V = VALUE_BITS;
  localparam int CW = $clog2(V + 1);

  logic [2*V-1:0] val_r;
  logic [V+1:0]   rem_r;
  logic [V-1:0]   root_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [V+1:0]   remx, trial;
  logic           ge;

  // partial remainder stays below 2^V before the shift, so no bits are lost
  assign remx  = {rem_r[V-1:0], val_r[2*V-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign ge    = remx >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        val_r  <= {u, {V{1'b0}}};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        val_r  <= val_r << 2;
        rem_r  <= ge ? remx - trial : remx;
        root_r <= {root_r[V-2:0], ge};
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == CW'(V - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
